/* rtl/core/string_hash_linear_probe_table_assert.svh */
// Assertion macros shared by the string hash table RTL.
`ifndef STRING_HASH_LINEAR_PROBE_TABLE_ASSERT_SVH
`define STRING_HASH_LINEAR_PROBE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/shlp_pkg.sv */
// Shared types, codes and hash helpers for the string hash table.
`timescale 1ns / 1ps

package shlp_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Hash and key widths.
   localparam int HASH_W = 32;
   localparam int SUM_W = 24;
   localparam int VALUE_W = 16;
   localparam logic [HASH_W-1:0] HASH_SEED = 32'd1315423911;

   // One table entry as held in the memory.
   typedef struct packed {
      logic               used;
      logic [SUM_W-1:0]   sum;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Control states of the top level, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MOD   = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Upper-case ASCII letters fold to lower case before hashing.
   function automatic logic [7:0] fold_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   // One shift-xor hash update.
   function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
      logic [HASH_W-1:0] mix;
      mix = (h << 5) + {24'd0, fold_lower(b)} + (h >> 2);
      return h ^ mix;
   endfunction

endpackage

/* rtl/core/shlp_hash.sv */
// Byte-serial hash and key-sum accumulators.
`timescale 1ns / 1ps

module shlp_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_en,
   input  logic [7:0]                 char_byte,
   input  logic                       last_byte,
   output logic [shlp_pkg::HASH_W-1:0] hash_next,
   output logic [shlp_pkg::SUM_W-1:0]  sum_next
);
   import shlp_pkg::*;

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;

   // A zero byte leaves both accumulators as they are.
   always_comb begin
      hash_next = hash_ff;
      sum_next  = sum_ff;
      if (char_byte != 8'd0) begin
         hash_next = hash_step(hash_ff, char_byte);
         sum_next  = sum_ff + {16'd0, char_byte};
      end
   end

   // The last byte of a string returns the accumulators to their seeds.
   always_comb begin
      hash_in = hash_ff;
      sum_in  = sum_ff;
      if (byte_en) begin
         if (last_byte) begin
            hash_in = HASH_SEED;
            sum_in  = '0;
         end else begin
            hash_in = hash_next;
            sum_in  = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_SEED;
         sum_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

/* rtl/core/shlp_mod.sv */
// Remainder of the 32-bit hash by the table size through a reciprocal multiply.
`timescale 1ns / 1ps

module shlp_mod #(
   parameter int TABLE_SIZE = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [shlp_pkg::HASH_W-1:0] dividend,
   output logic                        done,
   output logic [$clog2(TABLE_SIZE)-1:0] remainder
);
   import shlp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W:0] DIVISOR = (IDX_W + 1)'(TABLE_SIZE);
   // Reciprocal of the table size scaled by 2^32 and rounded down.
   localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / TABLE_SIZE);

   logic [HASH_W-1:0]   hash_ff;
   logic [2*HASH_W-1:0] prod;
   logic [IDX_W:0]      quot_lo_ff;
   logic [IDX_W:0]      hash_lo_ff;
   logic [IDX_W:0]      fold;
   logic [IDX_W:0]      rem_in;
   logic [IDX_W-1:0]    rem_ff;
   logic                load_ff;
   logic                mult_ff;
   logic                done_ff;

   // The estimated quotient equals the true quotient or falls one short of it.
   assign prod = (2*HASH_W)'(hash_ff) * (2*HASH_W)'(RECIP);

   // The partial remainder is below twice the divisor, so its low bits are exact.
   always_comb begin
      fold   = hash_lo_ff - quot_lo_ff * DIVISOR;
      rem_in = fold;
      if (fold >= DIVISOR) begin
         rem_in = fold - DIVISOR;
      end
   end

   // Control: one flag per stage, done pulses when the remainder is ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         mult_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= start;
         mult_ff <= load_ff;
         done_ff <= mult_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         hash_ff <= dividend;
      end
      if (load_ff) begin
         quot_lo_ff <= prod[HASH_W +: IDX_W + 1];
         hash_lo_ff <= hash_ff[IDX_W:0];
      end
      if (mult_ff) begin
         rem_ff <= rem_in[IDX_W-1:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/core/shlp_store.sv */
// Slot memory with one write and one registered read port, plus the clearing sweep.
`timescale 1ns / 1ps

module shlp_store #(
   parameter int TABLE_SIZE = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  shlp_pkg::entry_type           wr_entry,
   input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output shlp_pkg::entry_type           rd_entry,
   output logic                          clr_active
);
   import shlp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_SIZE - 1);

   entry_type        mem [TABLE_SIZE];
   entry_type        rd_entry_ff;
   logic             clr_active_ff;
   logic [IDX_W-1:0] clr_addr_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd;

   // The clearing sweep owns the write port until every slot reads empty.
   always_comb begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_entry;
      if (clr_active_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Memory array.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry   = rd_entry_ff;
   assign clr_active = clr_active_ff;

endmodule

/* rtl/core/string_hash_linear_probe_table.sv */
// Flow: a non-final byte or an unused kind gives no word; the next word can follow at once.
// A final byte gives its word after the remainder unit (hash, quotient and remainder registers),
// the home slot read, one probe per slot read (1 to TABLE_SIZE slots), the pending result and the output register.
// A remove goes from acceptance straight to the emit state and then into the output register.
// Throughput: one string byte per cycle while req_stall is low; a final byte or a remove holds off the next word
// until its result is in the output register. Reset clears control, then a sweep empties every slot.
`timescale 1ns / 1ps

module string_hash_linear_probe_table #(
   parameter int TABLE_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_item_value,
   input  logic [7:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic        rsp_table_full,
   output logic [7:0]  rsp_slot,
   output logic [15:0] rsp_value_out
);
   import shlp_pkg::*;
   `include "string_hash_linear_probe_table_assert.svh"

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_SIZE - 1);

   state_type          state_ff;
   state_type          state_in;
   logic [SUM_W-1:0]   key_ff;
   logic [VALUE_W-1:0] item_ff;
   logic               insert_ff;
   logic [IDX_W-1:0]   cur_addr_ff;
   logic [IDX_W-1:0]   cnt_ff;
   logic               pend_found_ff;
   logic               pend_full_ff;
   logic [7:0]         pend_slot_ff;
   logic [VALUE_W-1:0] pend_value_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic               rsp_table_full_ff;
   logic [7:0]         rsp_slot_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic               req_take;
   logic               take_string;
   logic               take_last;
   logic               take_remove;
   logic               remove_ok;
   logic               out_free;
   logic [HASH_W-1:0]  hash_next;
   logic [SUM_W-1:0]   sum_next;
   logic               mod_done;
   logic [IDX_W-1:0]   mod_rem;
   logic               clr_active;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   entry_type          mem_wr_entry;
   logic [IDX_W-1:0]   mem_rd_addr;
   entry_type          rd_entry;
   logic [IDX_W-1:0]   next_addr;
   logic               probe_stop;
   logic               probe_found;
   logic               probe_full;
   logic [VALUE_W-1:0] probe_value;

   // Input word decode.
   assign req_stall   = (state_ff != ST_IDLE) || clr_active;
   assign req_take    = req_valid && !req_stall;
   assign take_string = req_take && (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP);
   assign take_last   = take_string && req_last_byte;
   assign take_remove = req_take && (req_kind == KIND_REMOVE);
   assign remove_ok   = 32'(req_slot_index) < 32'(TABLE_SIZE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   shlp_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (take_string),
      .char_byte (req_char_byte),
      .last_byte (req_last_byte),
      .hash_next (hash_next),
      .sum_next  (sum_next)
   );

   shlp_mod #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (take_last),
      .dividend  (hash_next),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   shlp_store #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_entry   (mem_wr_entry),
      .rd_addr    (mem_rd_addr),
      .rd_entry   (rd_entry),
      .clr_active (clr_active)
   );

   // Probe address walks the table and wraps at the end.
   assign next_addr   = (cur_addr_ff == LAST_ADDR) ? '0 : IDX_W'(cur_addr_ff + 1'b1);
   assign mem_rd_addr = mod_done ? mod_rem : next_addr;

   // Evaluate the slot read last cycle.
   always_comb begin
      probe_stop  = 1'b0;
      probe_found = 1'b0;
      probe_full  = 1'b0;
      probe_value = '0;
      if (insert_ff) begin
         if (!rd_entry.used) begin
            probe_stop  = 1'b1;
            probe_found = 1'b1;
         end else if (cnt_ff == LAST_ADDR) begin
            probe_stop = 1'b1;
            probe_full = 1'b1;
         end
      end else begin
         if (!rd_entry.used) begin
            probe_stop = 1'b1;
         end else if (rd_entry.sum == key_ff) begin
            probe_stop  = 1'b1;
            probe_found = 1'b1;
            probe_value = rd_entry.value;
         end else if (cnt_ff == LAST_ADDR) begin
            probe_stop = 1'b1;
         end
      end
   end

   // Memory writes: a remove frees a slot at accept, an insert fills the free slot.
   always_comb begin
      mem_wr_en          = 1'b0;
      mem_wr_addr        = cur_addr_ff;
      mem_wr_entry.used  = 1'b1;
      mem_wr_entry.sum   = key_ff;
      mem_wr_entry.value = item_ff;
      if (take_remove && remove_ok) begin
         mem_wr_en         = 1'b1;
         mem_wr_addr       = IDX_W'(req_slot_index);
         mem_wr_entry.used = 1'b0;
      end else if (state_ff == ST_PROBE && insert_ff && probe_found) begin
         mem_wr_en = 1'b1;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_last) begin
               state_in = ST_MOD;
            end else if (take_remove) begin
               state_in = ST_EMIT;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_stop) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operation context and probe bookkeeping.
   always_ff @(posedge clock) begin
      if (take_last) begin
         key_ff    <= sum_next;
         item_ff   <= req_item_value;
         insert_ff <= (req_kind == KIND_INSERT);
      end
      if (mod_done) begin
         cur_addr_ff <= mod_rem;
         cnt_ff      <= '0;
      end else if (state_ff == ST_PROBE && !probe_stop) begin
         cur_addr_ff <= next_addr;
         cnt_ff      <= cnt_ff + 1'b1;
      end
   end

   // Pending result, waiting for the output register.
   always_ff @(posedge clock) begin
      if (take_remove) begin
         pend_found_ff <= remove_ok;
         pend_full_ff  <= 1'b0;
         pend_slot_ff  <= remove_ok ? req_slot_index : 8'd0;
         pend_value_ff <= '0;
      end else if (state_ff == ST_PROBE && probe_stop) begin
         pend_found_ff <= probe_found;
         pend_full_ff  <= probe_full;
         pend_slot_ff  <= probe_found ? 8'(cur_addr_ff) : 8'd0;
         pend_value_ff <= probe_value;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_found_ff      <= pend_found_ff;
         rsp_table_full_ff <= pend_full_ff;
         rsp_slot_ff       <= pend_slot_ff;
         rsp_value_ff      <= pend_value_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_table_full_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_value_out  = rsp_value_ff;

   // Checks.
   `SHLP_ASSERT_SAME(a_mod_done_in_mod, clock, reset, mod_done, state_ff == ST_MOD, "remainder finished outside the remainder state")
   `SHLP_ASSERT_SAME(a_insert_to_free, clock, reset, state_ff == ST_PROBE && mem_wr_en, !rd_entry.used, "insert wrote an occupied slot")
   `SHLP_ASSERT_SAME(a_no_take_in_clear, clock, reset, clr_active, !req_take, "word accepted during the clearing sweep")
   `SHLP_ASSERT_NEXT(a_emit_loads, clock, reset, state_ff == ST_EMIT && out_free, rsp_valid_ff && state_ff == ST_IDLE, "pending result not moved to the output")

endmodule

/* tb/tag_table_checker.sv */
// Checker for the string hash table: predicts every result word and compares it.
`timescale 1ns / 1ps

module tag_table_checker #(
   parameter int TBL_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_item_value,
   input  logic [7:0]  req_slot_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_found,
   input  logic        rsp_table_full,
   input  logic [7:0]  rsp_slot,
   input  logic [15:0] rsp_value_out,
   output int          fail_count,
   output int          pending
);
   import shlp_pkg::*;

   // One predicted result word.
   typedef struct packed {
      logic        found;
      logic        full;
      logic [7:0]  slot;
      logic [15:0] value;
   } tag_answer_type;

   // Running string key and the table contents as the block should hold them.
   logic [31:0] key_hash;
   logic [23:0] key_sum;
   logic        slot_busy [TBL_SLOTS];
   logic [23:0] slot_key  [TBL_SLOTS];
   logic [15:0] slot_item [TBL_SLOTS];
   tag_answer_type answers_due [$];

   // Prints one line per mismatch and counts it.
   task automatic flag_mismatch(input string msg);
      $display("%0t ns tag table checker: %s", $time, msg);
      fail_count++;
   endtask

   // Folds one accepted request word into the key or the table.
   task automatic absorb_word(input logic [1:0] kind, input logic [7:0] ch,
                              input logic last, input logic [15:0] item,
                              input logic [7:0] idx);
      logic [31:0] h;
      logic [31:0] mix;
      logic [7:0]  lc;
      logic [23:0] key;
      int unsigned pos;
      int          n;
      logic        done;
      logic        hit;
      h = key_hash;
      lc = ch;
      done = 1'b0;
      hit = 1'b0;
      if (kind == KIND_REMOVE) begin
         // A remove leaves the running key alone, so it may sit inside a string.
         if (int'(idx) < TBL_SLOTS) begin
            slot_busy[idx] = 1'b0;
            answers_due.push_back('{1'b1, 1'b0, idx, 16'd0});
         end else begin
            answers_due.push_back('{1'b0, 1'b0, 8'd0, 16'd0});
         end
      end else if (kind == KIND_INSERT || kind == KIND_LOOKUP) begin
         // A zero byte leaves both the hash and the sum unchanged.
         if (ch != 8'd0) begin
            if (ch >= 8'h41 && ch <= 8'h5A) begin
               lc = ch + 8'h20;
            end
            mix = (h << 5) + {24'd0, lc} + (h >> 2);
            key_hash = h ^ mix;
            key_sum = key_sum + {16'd0, ch};
         end
         if (last) begin
            pos = key_hash % TBL_SLOTS;
            key = key_sum;
            key_hash = HASH_SEED;
            key_sum = '0;
            if (kind == KIND_INSERT) begin
               // Take the first free slot from the home slot on, wrapping.
               for (n = 0; n < TBL_SLOTS && !done; n++) begin
                  if (!slot_busy[pos]) begin
                     slot_busy[pos] = 1'b1;
                     slot_key[pos] = key;
                     slot_item[pos] = item;
                     done = 1'b1;
                     hit = 1'b1;
                  end else begin
                     pos = (pos + 1) % TBL_SLOTS;
                  end
               end
               if (hit) begin
                  answers_due.push_back('{1'b1, 1'b0, pos[7:0], 16'd0});
               end else begin
                  answers_due.push_back('{1'b0, 1'b1, 8'd0, 16'd0});
               end
            end else begin
               // A lookup ends at an empty slot, a matching sum, or a full lap.
               for (n = 0; n < TBL_SLOTS && !done; n++) begin
                  if (!slot_busy[pos]) begin
                     done = 1'b1;
                  end else if (slot_key[pos] == key) begin
                     done = 1'b1;
                     hit = 1'b1;
                  end else begin
                     pos = (pos + 1) % TBL_SLOTS;
                  end
               end
               if (hit) begin
                  answers_due.push_back('{1'b1, 1'b0, pos[7:0], slot_item[pos]});
               end else begin
                  answers_due.push_back('{1'b0, 1'b0, 8'd0, 16'd0});
               end
            end
         end
      end
   endtask

   // Compares one result word against the oldest prediction.
   task automatic check_word();
      tag_answer_type want;
      if (answers_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected word found=%0b full=%0b slot=%0d value=%h",
                                 rsp_found, rsp_table_full, rsp_slot, rsp_value_out));
      end else begin
         want = answers_due.pop_front();
         if (rsp_found !== want.found) begin
            flag_mismatch($sformatf("found is %b, want %b", rsp_found, want.found));
         end
         if (rsp_table_full !== want.full) begin
            flag_mismatch($sformatf("table_full is %b, want %b", rsp_table_full, want.full));
         end
         if (rsp_slot !== want.slot) begin
            flag_mismatch($sformatf("slot is %0d, want %0d", rsp_slot, want.slot));
         end
         if (rsp_value_out !== want.value) begin
            flag_mismatch($sformatf("value_out is %h, want %h", rsp_value_out, want.value));
         end
      end
   endtask

   // Watch both channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         key_hash = HASH_SEED;
         key_sum = '0;
         for (int i = 0; i < TBL_SLOTS; i++) begin
            slot_busy[i] = 1'b0;
         end
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_word();
         end
         if (req_valid && !req_stall) begin
            absorb_word(req_kind, req_char_byte, req_last_byte, req_item_value,
                        req_slot_index);
         end
      end
      pending = answers_due.size();
   end

endmodule

/* tb/tb_top.sv */
// Top of the string hash table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import shlp_pkg::*;

   localparam int SLOTS = 256;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE_CYCLES = 300;
   localparam int POOL_DEPTH = 32;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // A key string of up to eight bytes, first byte in the low bits.
   typedef struct packed {
      logic [3:0]  len;
      logic [63:0] bytes;
   } key_text_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [7:0]  req_char_byte;
   logic        req_last_byte;
   logic [15:0] req_item_value;
   logic [7:0]  req_slot_index;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic        rsp_table_full;
   logic [7:0]  rsp_slot;
   logic [15:0] rsp_value_out;

   int mismatches;
   int answers_waiting;
   int tx_idle_pct;
   int rx_stall_pct;
   int cycle_count;
   int words_sent;
   key_text_type key_pool [$];

   always #1 clock = ~clock;

   string_hash_linear_probe_table #(.TABLE_SIZE(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_char_byte(req_char_byte),
      .req_last_byte(req_last_byte),
      .req_item_value(req_item_value),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_table_full(rsp_table_full),
      .rsp_slot(rsp_slot),
      .rsp_value_out(rsp_value_out)
   );

   tag_table_checker #(.TBL_SLOTS(SLOTS)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_char_byte(req_char_byte),
      .req_last_byte(req_last_byte),
      .req_item_value(req_item_value),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_table_full(rsp_table_full),
      .rsp_slot(rsp_slot),
      .rsp_value_out(rsp_value_out),
      .fail_count(mismatches),
      .pending(answers_waiting)
   );

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Offers one word, with random idle cycles first, and waits until it is taken.
   // Called at a falling edge and returns at a falling edge.
   task automatic push_word(input logic [1:0] kind, input logic [7:0] ch,
                            input logic last, input logic [15:0] item,
                            input logic [7:0] idx);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         req_char_byte <= 8'($urandom);
         req_item_value <= 16'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_char_byte <= ch;
      req_last_byte <= last;
      req_item_value <= item;
      req_slot_index <= idx;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (kind != KIND_UNUSED) begin
         words_sent++;
      end
   endtask

   // Stops sending until every predicted word has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (answers_waiting != 0) begin
         @(negedge clock);
      end
   endtask

   // Builds a random key: mostly letters of both cases, some zeros and raw bytes.
   function automatic key_text_type make_text();
      key_text_type t;
      int n;
      int r;
      logic [7:0] c;
      t.bytes = '0;
      n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
      t.len = n[3:0];
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            c = 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
         end else if (r < 6) begin
            c = 8'h00;
         end else begin
            c = 8'($urandom_range(0, 255));
         end
         t.bytes[8*i +: 8] = c;
      end
      return t;
   endfunction

   // Swaps the end bytes (same sum, other hash) or flips the case of the first.
   function automatic key_text_type twist_text(input key_text_type t);
      key_text_type v;
      logic [7:0] c;
      int n;
      v = t;
      n = int'(t.len);
      if (n >= 2 && $urandom_range(0, 1)) begin
         v.bytes[7:0] = t.bytes[8*(n-1) +: 8];
         v.bytes[8*(n-1) +: 8] = t.bytes[7:0];
      end else if (n >= 1) begin
         c = t.bytes[7:0];
         if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            v.bytes[7:0] = c ^ 8'h20;
         end
      end
      return v;
   endfunction

   // Sends a key a byte at a time; when noisy, stray kinds and removes fall inside.
   task automatic send_text(input logic [1:0] kind, input key_text_type t,
                            input logic [15:0] item, input logic noisy);
      logic [1:0] k;
      int n;
      n = int'(t.len);
      if (n == 0) begin
         push_word(kind, 8'h00, 1'b1, item, 8'($urandom));
      end else begin
         for (int i = 0; i < n; i++) begin
            k = kind;
            if (noisy) begin
               if ($urandom_range(0, 99) < 5) begin
                  k = (kind == KIND_INSERT) ? KIND_LOOKUP : KIND_INSERT;
               end
               if ($urandom_range(0, 99) < 4) begin
                  push_word(KIND_REMOVE, 8'($urandom), 1'($urandom), 16'($urandom),
                            8'($urandom));
               end
               if ($urandom_range(0, 99) < 3) begin
                  push_word(KIND_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom),
                            8'($urandom));
               end
            end
            push_word(k, t.bytes[8*i +: 8], i == n - 1,
                      (i == n - 1) ? item : 16'($urandom), 8'($urandom));
         end
      end
   endtask

   // Random mix of inserts, lookups of known and altered keys, removes and noise.
   task automatic run_mix(input int count);
      int start;
      int r;
      key_text_type t;
      start = words_sent;
      while (words_sent - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            t = make_text();
            send_text(KIND_INSERT, t, 16'($urandom), 1'b1);
            key_pool.push_back(t);
            if (key_pool.size() > POOL_DEPTH) begin
               void'(key_pool.pop_front());
            end
         end else if (r < 55) begin
            if (key_pool.size() > 0 && $urandom_range(0, 9) < 6) begin
               t = key_pool[$urandom_range(0, key_pool.size() - 1)];
               if ($urandom_range(0, 3) == 0) begin
                  t = twist_text(t);
               end
            end else begin
               t = make_text();
            end
            send_text(KIND_LOOKUP, t, 16'($urandom), 1'b1);
         end else if (r < 92) begin
            push_word(KIND_REMOVE, 8'($urandom), 1'($urandom), 16'($urandom),
                      8'($urandom_range(0, 255)));
         end else begin
            push_word(KIND_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom),
                      8'($urandom));
         end
      end
   endtask

   // Fills every slot with one-byte keys, probes the full table, then empties it again.
   task automatic fill_and_clear();
      int first;
      for (int i = 0; i < SLOTS + 2; i++) begin
         push_word(KIND_INSERT, 8'($urandom), 1'b1, 16'($urandom), 8'($urandom));
      end
      for (int i = 0; i < 3; i++) begin
         send_text(KIND_LOOKUP, make_text(), 16'($urandom), 1'b0);
      end
      push_word(KIND_INSERT, 8'h00, 1'b1, 16'hFFFF, 8'h00);
      first = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
         push_word(KIND_REMOVE, 8'($urandom), 1'($urandom), 16'($urandom),
                   8'((first + i) % SLOTS));
      end
      push_word(KIND_LOOKUP, 8'h00, 1'b1, 16'h0000, 8'h00);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_INSERT;
      req_char_byte = 8'h00;
      req_last_byte = 1'b0;
      req_item_value = 16'h0000;
      req_slot_index = 8'h00;
      tx_idle_pct = 34;
      rx_stall_pct = 52;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Empty key stored and found again.
      push_word(KIND_INSERT, 8'h00, 1'b1, 16'hFFFF, 8'h00);
      push_word(KIND_LOOKUP, 8'h00, 1'b1, 16'h0000, 8'hFF);
      // Case folding: "aB" hashes like "Ab" and has the same byte sum; "ab" does not.
      push_word(KIND_INSERT, 8'h41, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_INSERT, 8'h62, 1'b1, 16'h1234, 8'h00);
      push_word(KIND_LOOKUP, 8'h61, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_LOOKUP, 8'h42, 1'b1, 16'h0000, 8'h00);
      push_word(KIND_LOOKUP, 8'h61, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_LOOKUP, 8'h62, 1'b1, 16'h0000, 8'h00);
      // Extreme bytes with a zero byte that adds nothing.
      push_word(KIND_INSERT, 8'hFF, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_INSERT, 8'h80, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_INSERT, 8'h00, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_INSERT, 8'h7F, 1'b1, 16'h8001, 8'h00);
      push_word(KIND_LOOKUP, 8'hFF, 1'b0, 16'hFFFF, 8'hFF);
      push_word(KIND_LOOKUP, 8'h80, 1'b0, 16'hFFFF, 8'hFF);
      push_word(KIND_LOOKUP, 8'h00, 1'b0, 16'hFFFF, 8'hFF);
      push_word(KIND_LOOKUP, 8'h7F, 1'b1, 16'hFFFF, 8'hFF);
      // Mixed kinds within a key: the last byte decides the operation.
      push_word(KIND_INSERT, 8'h78, 1'b0, 16'h5555, 8'h00);
      push_word(KIND_LOOKUP, 8'h79, 1'b1, 16'hAAAA, 8'h00);
      // A remove inside a key does not disturb the running key.
      push_word(KIND_LOOKUP, 8'h41, 1'b0, 16'h0000, 8'h00);
      push_word(KIND_REMOVE, 8'h00, 1'b1, 16'h0000, 8'd255);
      push_word(KIND_LOOKUP, 8'h62, 1'b1, 16'h0000, 8'h00);
      // The unused kind is dropped without a word.
      push_word(KIND_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 8'hFF);
      // Lowest and highest slot; every slot index is in range at this table size.
      push_word(KIND_REMOVE, 8'h00, 1'b0, 16'h0000, 8'd0);
      push_word(KIND_REMOVE, 8'hFF, 1'b1, 16'hFFFF, 8'd255);

      run_mix(300);
      hold_until_drained();

      tx_idle_pct = 52;
      rx_stall_pct = 34;
      fill_and_clear();
      run_mix(100);
      hold_until_drained();

      tx_idle_pct = 0;
      rx_stall_pct = 0;
      run_mix(250);

      // Let the last words come back, then leave room for any stray word.
      req_valid <= 1'b0;
      @(negedge clock);
      while (answers_waiting != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
